[src/lmm_heritability_loglike_macros.svh]
// Assertion macros used by the sequencer of the log likelihood block.
`ifndef LMM_HERITABILITY_LOGLIKE_MACROS_SVH
`define LMM_HERITABILITY_LOGLIKE_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every rising clock edge outside reset.
`define LMMHL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// The expression must never be true at a rising clock edge outside reset.
`define LMMHL_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define LMMHL_ASSERT(lbl, clk, rstn, prop, msg)
`define LMMHL_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

[src/lmmhl_pkg.sv]
// Shared constants, types and request structs of the log likelihood block.
package lmmhl_pkg;

  localparam int unsigned MAX_ITEMS  = 4096;
  localparam int unsigned CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [15:0] HERIT_RESET = 16'd32768;
  localparam logic [31:0] RATIO_RESET = 32'd65536;
  localparam logic [47:0] L_MAX       = {1'b0, {47{1'b1}}};
  localparam logic [47:0] L_MIN       = {1'b1, {47{1'b0}}};

  typedef enum logic [1:0] {
    ST_OK,
    ST_ZERO_GG,
    ST_FEW_ITEMS,
    ST_ZERO_RSS
  } status_e;

  typedef struct packed {
    logic [31:0]      eig;
    logic [31:0]      phen;
    logic [31:0]      geno;
    logic             last;
    logic             acc;
    logic [CNT_W-1:0] n;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
    logic        frac32;
  } log_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] res;
  } log_rsp_t;

endpackage

[src/lmm_heritability_loglike.sv]
// Top level of the linear mixed model log likelihood block.
// Each transfer on the input side is one observation in the rotated basis. An item is
// taken at a rising edge with start high and busy low; busy rises only when the
// two-entry queue between the front end and the sequencer is full. Results cannot be
// held off: each appears on the result ports for exactly one cycle, marked by done_o,
// and only for an item marked last. The front end counts the set and classifies each
// item in the cycle it is taken, so new items keep flowing into the queue while the
// sequencer works. For an accumulated item the sequencer sends the three weighted
// terms y*y/V, g*y/V and g*g/V one after another through the shared divider, which
// retires one quotient bit per cycle, each term after its product; the logarithm of
// V runs alongside in its own unit. A last item then forms the closing quotient
// Sgy^2/Sgg, the division by n-2 and one more logarithm. A write to the heritability
// register occupies the divider to form h2/(1-h2) before the next queued item starts
// its arithmetic.
module lmm_heritability_loglike (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        eigenvalue_i,
  input  logic signed [31:0] phenotype_i,
  input  logic signed [31:0] genotype_i,
  input  logic               last_item_i,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               done_o,
  output logic signed [47:0] log_likelihood_o,
  output logic [1:0]         status_o
);

  lmmhl_pkg::entry_t   push_entry, pop_entry;
  lmmhl_pkg::div_req_t div_req;
  lmmhl_pkg::div_rsp_t div_rsp;
  lmmhl_pkg::log_req_t log_req;
  lmmhl_pkg::log_rsp_t log_rsp;
  logic push, pop, full, empty;

  // The queue being full is the only reason to turn a transfer away.
  assign busy = full;

  lmmhl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .full_i       (full),
    .eigenvalue_i (eigenvalue_i),
    .phenotype_i  (phenotype_i),
    .genotype_i   (genotype_i),
    .last_item_i  (last_item_i),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  lmmhl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .pop_i   (pop),
    .data_o  (pop_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  lmmhl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lmmhl_log u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (log_req),
    .rsp_o  (log_rsp)
  );

  // The sequencer owns the heritability register, so a write simply marks the ratio
  // stale and it is rebuilt before any later item uses it.
  lmmhl_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .empty_i          (empty),
    .entry_i          (pop_entry),
    .pop_o            (pop),
    .div_req_o        (div_req),
    .div_rsp_i        (div_rsp),
    .log_req_o        (log_req),
    .log_rsp_i        (log_rsp),
    .done_o           (done_o),
    .log_likelihood_o (log_likelihood_o),
    .status_o         (status_o)
  );

endmodule

[src/lmmhl_fifo.sv]
// Short show-ahead queue of classified items between the front and back ends.
module lmmhl_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lmmhl_pkg::entry_t   data_i,
  input  logic                pop_i,
  output lmmhl_pkg::entry_t   data_o,
  output logic                full_o,
  output logic                empty_o
);

  lmmhl_pkg::entry_t mem_q [lmmhl_pkg::FIFO_DEPTH];
  logic [lmmhl_pkg::PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [lmmhl_pkg::PTR_W:0]   fill_q, fill_d;
  logic push_ok, pop_ok;

  assign full_o  = (fill_q == (lmmhl_pkg::PTR_W + 1)'(lmmhl_pkg::FIFO_DEPTH));
  assign empty_o = (fill_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d   = push_ok ? wr_q + 1'b1 : wr_q;
    rd_d   = pop_ok ? rd_q + 1'b1 : rd_q;
    fill_d = fill_q + {{lmmhl_pkg::PTR_W{1'b0}}, push_ok}
                    - {{lmmhl_pkg::PTR_W{1'b0}}, pop_ok};
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

endmodule

[src/lmmhl_div.sv]
// Restoring divider, one quotient bit per cycle, for a 128 by 64 bit division.
module lmmhl_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lmmhl_pkg::div_req_t  req_i,
  output lmmhl_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned ITERS = 64;

  logic        busy_q, busy_d, done_q, done_d;
  logic [$clog2(ITERS)-1:0] cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d, lo_q, lo_d, quo_q, quo_d, den_q, den_d;
  logic [64:0] shifted;
  logic        ge;

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  always_comb begin
    shifted = {rem_q, lo_q[63]};
    ge      = (shifted >= {1'b0, den_q});
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    quo_d   = quo_q;
    den_d   = den_q;
    if (req_i.start) begin
      rem_d  = req_i.hi;
      lo_d   = req_i.lo;
      den_d  = req_i.den;
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? 64'(shifted - {1'b0, den_q}) : shifted[63:0];
      lo_d  = {lo_q[62:0], 1'b0};
      quo_d = {quo_q[62:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ($clog2(ITERS))'(ITERS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[src/lmmhl_log.sv]
// Natural logarithm unit: normalise, 24 squaring steps, scale by ln 2.
module lmmhl_log (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lmmhl_pkg::log_req_t  req_i,
  output lmmhl_pkg::log_rsp_t  rsp_o
);

  localparam int unsigned FRAC_BITS = 24;
  localparam logic [2:0] L_IDLE  = 3'd0;
  localparam logic [2:0] L_NORM  = 3'd1;
  localparam logic [2:0] L_SQ    = 3'd2;
  localparam logic [2:0] L_L2    = 3'd3;
  localparam logic [2:0] L_SCALE = 3'd4;

  logic [2:0]  state_q, state_d;
  logic        done_q, done_d;
  logic [2:0]  step_q, step_d;
  logic [4:0]  it_q, it_d;
  logic [63:0] x_q, x_d, xn;
  logic [5:0]  sh_q, sh_d;
  logic [30:0] m_q, m_d;
  logic [23:0] fb_q, fb_d;
  logic        f32_q, f32_d;
  logic [31:0] l2_q, l2_d, res_q, res_d;
  logic [6:0]  w, pf;
  logic        top_zero, neg;
  logic [61:0] sq;
  logic [31:0] t, mag;
  logic [63:0] prod;

  assign rsp_o.busy = (state_q != L_IDLE);
  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    step_d   = step_q;
    it_d     = it_q;
    x_d      = x_q;
    sh_d     = sh_q;
    m_d      = m_q;
    fb_d     = fb_q;
    f32_d    = f32_q;
    l2_d     = l2_q;
    res_d    = res_q;
    w        = 7'd32 >> step_q;
    top_zero = ((x_q & ~({64{1'b1}} >> w)) == '0);
    xn       = top_zero ? (x_q << w) : x_q;
    sq       = m_q * m_q;
    t        = sq[61:30];
    pf       = 7'(7'd63 - {1'b0, sh_q}) - (f32_q ? 7'd32 : 7'd16);
    neg      = l2_q[31];
    mag      = neg ? 32'(-l2_q) : l2_q;
    prod     = mag * lmmhl_pkg::LN2_Q32;
    case (state_q)
      L_IDLE: begin
        if (req_i.start) begin
          x_d     = req_i.x;
          f32_d   = req_i.frac32;
          sh_d    = '0;
          step_d  = '0;
          it_d    = '0;
          state_d = L_NORM;
        end
      end
      L_NORM: begin
        x_d    = xn;
        sh_d   = top_zero ? sh_q + w[5:0] : sh_q;
        step_d = step_q + 1'b1;
        if (step_q == 3'd5) begin
          m_d     = xn[63:33];
          state_d = L_SQ;
        end
      end
      L_SQ: begin
        m_d  = t[31] ? t[31:1] : t[30:0];
        fb_d = {fb_q[22:0], t[31]};
        it_d = it_q + 1'b1;
        if (it_q == 5'(FRAC_BITS - 1)) begin
          state_d = L_L2;
        end
      end
      L_L2: begin
        l2_d    = {pf[6], pf, fb_q};
        state_d = L_SCALE;
      end
      L_SCALE: begin
        res_d   = neg ? 32'(-prod[63:32]) : prod[63:32];
        done_d  = 1'b1;
        state_d = L_IDLE;
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    sh_q  <= sh_d;
    m_q   <= m_d;
    fb_q  <= fb_d;
    f32_q <= f32_d;
    l2_q  <= l2_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      step_q  <= step_d;
      it_q    <= it_d;
    end
  end

endmodule

[src/lmmhl_front.sv]
// Front end: takes input transfers, counts the set and classifies each item.
module lmmhl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               full_i,
  input  logic [31:0]        eigenvalue_i,
  input  logic signed [31:0] phenotype_i,
  input  logic signed [31:0] genotype_i,
  input  logic               last_item_i,
  output logic               push_o,
  output lmmhl_pkg::entry_t  entry_o
);

  logic [lmmhl_pkg::CNT_W-1:0] count_q, count_d, n;
  logic acc;

  always_comb begin
    push_o        = start_i && !full_i;
    acc           = (count_q < lmmhl_pkg::CNT_W'(lmmhl_pkg::MAX_ITEMS));
    n             = acc ? count_q + 1'b1 : count_q;
    entry_o.eig   = eigenvalue_i;
    entry_o.phen  = phenotype_i;
    entry_o.geno  = genotype_i;
    entry_o.last  = last_item_i;
    entry_o.acc   = acc;
    entry_o.n     = n;
    count_d       = count_q;
    if (push_o) begin
      count_d = last_item_i ? '0 : n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

[src/lmmhl_back.sv]
// Back end: sequencer that turns queued items into sums and the final result.
`include "lmm_heritability_loglike_macros.svh"
module lmmhl_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 empty_i,
  input  lmmhl_pkg::entry_t    entry_i,
  output logic                 pop_o,
  output lmmhl_pkg::div_req_t  div_req_o,
  input  lmmhl_pkg::div_rsp_t  div_rsp_i,
  output lmmhl_pkg::log_req_t  log_req_o,
  input  lmmhl_pkg::log_rsp_t  log_rsp_i,
  output logic                 done_o,
  output logic signed [47:0]   log_likelihood_o,
  output logic [1:0]           status_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RATIO = 5'd1;
  localparam logic [4:0] S_VMUL  = 5'd2;
  localparam logic [4:0] S_VLOG  = 5'd3;
  localparam logic [4:0] S_WMUL  = 5'd4;
  localparam logic [4:0] S_WDIVS = 5'd5;
  localparam logic [4:0] S_WDIV  = 5'd6;
  localparam logic [4:0] S_LWAIT = 5'd7;
  localparam logic [4:0] S_FIN   = 5'd8;
  localparam logic [4:0] S_GMUL  = 5'd9;
  localparam logic [4:0] S_GCHK  = 5'd10;
  localparam logic [4:0] S_QDIV  = 5'd11;
  localparam logic [4:0] S_QCHK  = 5'd12;
  localparam logic [4:0] S_VEDIV = 5'd13;
  localparam logic [4:0] S_LNVE  = 5'd14;
  localparam logic [4:0] S_NMUL  = 5'd15;
  localparam logic [4:0] S_LSUM  = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] a);
    mag32 = a[31] ? 32'(-a) : a;
  endfunction

  logic [4:0]  state_q, state_d;
  logic [15:0] herit_q, herit_d;
  logic [31:0] ratio_q, ratio_d;
  logic        rpend_q, rpend_d;
  logic [47:0] sum_log_q, sum_log_d;
  logic [63:0] syy_q, syy_d, sgy_q, sgy_d, sgg_q, sgg_d;
  logic        vld_q, vld_d;
  logic [47:0] ll_q, ll_d;
  lmmhl_pkg::status_e stat_q, stat_d, st_q, st_d;

  lmmhl_pkg::entry_t item_q, item_d;
  logic [48:0]  v_q, v_d;
  logic [1:0]   lane_q, lane_d, pstep_q, pstep_d;
  logic [63:0]  pp_q, pp_d, quo_q, quo_d, term, mgy;
  logic         sgn_q, sgn_d;
  logic [127:0] gacc_q, gacc_d;
  logic [31:0]  lnmag_q, lnmag_d, mul_a, mul_b, wa, wb;
  logic [47:0]  nl_q, nl_d, l_q, l_d;
  logic [63:0]  mprod;
  logic [48:0]  s49;
  logic signed [49:0] s50, nl50;

  assign mprod            = mul_a * mul_b;
  assign done_o           = vld_q;
  assign log_likelihood_o = ll_q;
  assign status_o         = stat_q;

  always_comb begin
    state_d   = state_q;
    herit_d   = herit_q;
    ratio_d   = ratio_q;
    rpend_d   = rpend_q;
    sum_log_d = sum_log_q;
    syy_d     = syy_q;
    sgy_d     = sgy_q;
    sgg_d     = sgg_q;
    vld_d     = 1'b0;
    ll_d      = ll_q;
    stat_d    = stat_q;
    st_d      = st_q;
    item_d    = item_q;
    v_d       = v_q;
    lane_d    = lane_q;
    pstep_d   = pstep_q;
    pp_d      = pp_q;
    quo_d     = quo_q;
    sgn_d     = sgn_q;
    gacc_d    = gacc_q;
    lnmag_d   = lnmag_q;
    nl_d      = nl_q;
    l_d       = l_q;
    pop_o     = 1'b0;
    div_req_o = '0;
    log_req_o = '0;
    mul_a     = '0;
    mul_b     = '0;
    wa        = (lane_q == 2'd0) ? item_q.phen : item_q.geno;
    wb        = (lane_q == 2'd2) ? item_q.geno : item_q.phen;
    term      = sgn_q ? 64'(-div_rsp_i.quo) : div_rsp_i.quo;
    mgy       = sgy_q[63] ? 64'(-sgy_q) : sgy_q;
    s49       = {1'b0, sum_log_q} + {17'b0, log_rsp_i.res};
    nl50      = $signed({2'b0, nl_q});
    s50       = $signed({{2{sum_log_q[47]}}, sum_log_q}) + (sgn_q ? -nl50 : nl50);

    case (state_q)
      S_IDLE: begin
        if (rpend_q) begin
          div_req_o.start = 1'b1;
          div_req_o.lo    = {32'b0, herit_q, 16'b0};
          div_req_o.den   = {47'b0, 17'(17'h10000 - {1'b0, herit_q})};
          rpend_d         = 1'b0;
          state_d         = S_RATIO;
        end else if (!empty_i) begin
          pop_o  = 1'b1;
          item_d = entry_i;
          if (entry_i.acc) begin
            state_d = S_VMUL;
          end else if (entry_i.last) begin
            state_d = S_FIN;
          end
        end
      end
      S_RATIO: begin
        if (div_rsp_i.done) begin
          ratio_d = div_rsp_i.quo[31:0];
          state_d = S_IDLE;
        end
      end
      S_VMUL: begin
        mul_a   = item_q.eig;
        mul_b   = ratio_q;
        v_d     = 49'd65536 + {1'b0, mprod[63:16]};
        state_d = S_VLOG;
      end
      S_VLOG: begin
        log_req_o.start = 1'b1;
        log_req_o.x     = {15'b0, v_q};
        lane_d          = 2'd0;
        state_d         = S_WMUL;
      end
      S_WMUL: begin
        mul_a   = mag32(wa);
        mul_b   = mag32(wb);
        pp_d    = mprod;
        sgn_d   = wa[31] ^ wb[31];
        state_d = S_WDIVS;
      end
      S_WDIVS: begin
        div_req_o.start = 1'b1;
        div_req_o.hi    = {48'b0, pp_q[63:48]};
        div_req_o.lo    = {pp_q[47:0], 16'b0};
        div_req_o.den   = {15'b0, v_q};
        state_d         = S_WDIV;
      end
      S_WDIV: begin
        if (div_rsp_i.done) begin
          case (lane_q)
            2'd0:    syy_d = sat_add64(syy_q, term);
            2'd1:    sgy_d = sat_add64(sgy_q, term);
            default: sgg_d = sat_add64(sgg_q, term);
          endcase
          if (lane_q == 2'd2) begin
            state_d = S_LWAIT;
          end else begin
            lane_d  = lane_q + 1'b1;
            state_d = S_WMUL;
          end
        end
      end
      S_LWAIT: begin
        if (!log_rsp_i.busy) begin
          sum_log_d = (s49 > {1'b0, lmmhl_pkg::L_MAX}) ? lmmhl_pkg::L_MAX : s49[47:0];
          state_d   = item_q.last ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (sgg_q[63] || sgg_q == '0) begin
          st_d    = lmmhl_pkg::ST_ZERO_GG;
          state_d = S_OUT;
        end else if (item_q.n <= lmmhl_pkg::CNT_W'(2)) begin
          st_d    = lmmhl_pkg::ST_FEW_ITEMS;
          state_d = S_OUT;
        end else begin
          gacc_d  = '0;
          pstep_d = '0;
          state_d = S_GMUL;
        end
      end
      S_GMUL: begin
        mul_a   = pstep_q[0] ? mgy[63:32] : mgy[31:0];
        mul_b   = pstep_q[1] ? mgy[63:32] : mgy[31:0];
        case (pstep_q)
          2'd0:    gacc_d = gacc_q + {64'b0, mprod};
          2'd3:    gacc_d = gacc_q + {mprod, 64'b0};
          default: gacc_d = gacc_q + {32'b0, mprod, 32'b0};
        endcase
        pstep_d = pstep_q + 1'b1;
        if (pstep_q == 2'd3) begin
          state_d = S_GCHK;
        end
      end
      S_GCHK: begin
        if (gacc_q[127:64] >= sgg_q) begin
          quo_d   = '1;
          state_d = S_QCHK;
        end else begin
          div_req_o.start = 1'b1;
          div_req_o.hi    = gacc_q[127:64];
          div_req_o.lo    = gacc_q[63:0];
          div_req_o.den   = sgg_q;
          state_d         = S_QDIV;
        end
      end
      S_QDIV: begin
        if (div_rsp_i.done) begin
          quo_d   = div_rsp_i.quo;
          state_d = S_QCHK;
        end
      end
      S_QCHK: begin
        if (syy_q[63] || syy_q == '0 || quo_q >= syy_q) begin
          st_d    = lmmhl_pkg::ST_ZERO_RSS;
          state_d = S_OUT;
        end else begin
          div_req_o.start = 1'b1;
          div_req_o.lo    = syy_q - quo_q;
          div_req_o.den   = 64'(item_q.n - lmmhl_pkg::CNT_W'(2));
          state_d         = S_VEDIV;
        end
      end
      S_VEDIV: begin
        if (div_rsp_i.done) begin
          if (div_rsp_i.quo == '0) begin
            st_d    = lmmhl_pkg::ST_ZERO_RSS;
            state_d = S_OUT;
          end else begin
            log_req_o.start  = 1'b1;
            log_req_o.x      = div_rsp_i.quo;
            log_req_o.frac32 = 1'b1;
            state_d          = S_LNVE;
          end
        end
      end
      S_LNVE: begin
        if (log_rsp_i.done) begin
          lnmag_d = mag32(log_rsp_i.res);
          sgn_d   = log_rsp_i.res[31];
          state_d = S_NMUL;
        end
      end
      S_NMUL: begin
        mul_a   = 32'(item_q.n);
        mul_b   = lnmag_q;
        nl_d    = mprod[47:0];
        state_d = S_LSUM;
      end
      S_LSUM: begin
        if (s50 > $signed({2'b0, lmmhl_pkg::L_MAX})) begin
          l_d = lmmhl_pkg::L_MAX;
        end else if (s50 < $signed({2'b11, lmmhl_pkg::L_MIN})) begin
          l_d = lmmhl_pkg::L_MIN;
        end else begin
          l_d = s50[47:0];
        end
        st_d    = lmmhl_pkg::ST_OK;
        state_d = S_OUT;
      end
      S_OUT: begin
        vld_d     = 1'b1;
        ll_d      = (st_q == lmmhl_pkg::ST_OK) ? l_q : '0;
        stat_d    = st_q;
        sum_log_d = '0;
        syy_d     = '0;
        sgy_d     = '0;
        sgg_d     = '0;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      herit_d = cfg_wdata_i;
      rpend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    ll_q    <= ll_d;
    stat_q  <= stat_d;
    st_q    <= st_d;
    item_q  <= item_d;
    v_q     <= v_d;
    pp_q    <= pp_d;
    quo_q   <= quo_d;
    sgn_q   <= sgn_d;
    gacc_q  <= gacc_d;
    lnmag_q <= lnmag_d;
    nl_q    <= nl_d;
    l_q     <= l_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      herit_q   <= lmmhl_pkg::HERIT_RESET;
      ratio_q   <= lmmhl_pkg::RATIO_RESET;
      rpend_q   <= 1'b0;
      sum_log_q <= '0;
      syy_q     <= '0;
      sgy_q     <= '0;
      sgg_q     <= '0;
      vld_q     <= 1'b0;
      lane_q    <= '0;
      pstep_q   <= '0;
    end else begin
      state_q   <= state_d;
      herit_q   <= herit_d;
      ratio_q   <= ratio_d;
      rpend_q   <= rpend_d;
      sum_log_q <= sum_log_d;
      syy_q     <= syy_d;
      sgy_q     <= sgy_d;
      sgg_q     <= sgg_d;
      vld_q     <= vld_d;
      lane_q    <= lane_d;
      pstep_q   <= pstep_d;
    end
  end

  // A result strobe lasts one cycle, since the sequencer leaves the output state at once.
  `LMMHL_ASSERT(a_strobe_single, clk_i, rst_ni, vld_q |=> !vld_q, "result strobe held")
  // A flagged result carries a zero likelihood.
  `LMMHL_ASSERT(a_flag_zero, clk_i, rst_ni, (vld_q && stat_q != lmmhl_pkg::ST_OK) |-> (ll_q == '0), "flagged result not zero")
  // The divider is only started when it is free.
  `LMMHL_NEVER(a_div_free, clk_i, rst_ni, div_req_o.start && div_rsp_i.busy, "divider restarted while busy")
  // The logarithm unit is only started when it is free.
  `LMMHL_NEVER(a_log_free, clk_i, rst_ni, log_req_o.start && log_rsp_i.busy, "log unit restarted while busy")

endmodule
